[hdl/rwq_pkg.sv]
// Shared types and constants for the reader/writer request queue.
`default_nettype none
package rwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 16;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCAN   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_STATUS   = 1'b0,
    KIND_DISPATCH = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ID_ZERO  = 2'd0,
    ID_PEND  = 2'd1,
    ID_ENTRY = 2'd2
  } id_sel_t;

  typedef enum logic {
    W_TAIL = 1'b0,
    W_PREV = 1'b1
  } wsel_t;

  typedef struct packed {
    logic            is_rd;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_inc;
    logic    wen;
    wsel_t   wsel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_load;
    logic    blk_upd;
    logic    nf_set;
    logic    emit;
    kind_t   o_kind;
    status_t o_status;
    logic    o_ready;
    id_sel_t o_id;
    logic    o_last;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_full;
    logic idx_end;
    logic idx_zero;
    logic hit;
    logic e_rd;
    logic rd_mis;
    logic blocked;
    logic nf;
  } sts_t;

endpackage
`default_nettype wire

[hdl/rwq_datapath.sv]
// Queue store, walk index, request registers and result registers.
`default_nettype none
module rwq_datapath #(
  parameter int QUEUE_DEPTH = rwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rwq_pkg::ctl_t            ctl,
  output rwq_pkg::sts_t            sts,
  input  logic [1:0]               opcode,
  input  logic [rwq_pkg::ID_W-1:0] req_id,
  input  logic                     is_read,
  output logic                     strobe,
  output logic                     kind,
  output logic [1:0]               status,
  output logic                     ready_res,
  output logic [rwq_pkg::ID_W-1:0] issued_id,
  output logic                     last
);
  import rwq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem [QUEUE_DEPTH];
  entry_t          rdata;
  entry_t          wdata;
  logic [AW-1:0]   waddr;
  logic [CW-1:0]   idx_prev;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   idx;
  op_t             op;
  logic [ID_W-1:0] id_q;
  logic            rd_q;
  logic [ID_W-1:0] pend;
  logic            blocked;
  logic            nf;
  kind_t           kind_r;
  status_t         status_r;

  assign idx_prev = idx - CW'(1);

  always_comb begin
    case (ctl.wsel)
      W_TAIL: begin
        waddr = cnt[AW-1:0];
        wdata = '{is_rd: rd_q, id: id_q};
      end
      W_PREV: begin
        waddr = idx_prev[AW-1:0];
        wdata = rdata;
      end
      default: begin
        waddr = cnt[AW-1:0];
        wdata = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end else if (ctl.cnt_dec) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (ctl.load) begin
      op      <= op_t'(opcode);
      id_q    <= req_id;
      rd_q    <= is_read;
      blocked <= 1'b0;
      nf      <= 1'b0;
    end else begin
      if (ctl.blk_upd) begin
        blocked <= blocked | ~rdata.is_rd | ~rd_q;
      end
      if (ctl.nf_set) begin
        nf <= 1'b1;
      end
    end
    if (ctl.pend_load) begin
      pend <= rdata.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
    if (ctl.emit) begin
      kind_r    <= ctl.o_kind;
      status_r  <= ctl.o_status;
      ready_res <= ctl.o_ready;
      last      <= ctl.o_last;
      case (ctl.o_id)
        ID_PEND:  issued_id <= pend;
        ID_ENTRY: issued_id <= rdata.id;
        default:  issued_id <= '0;
      endcase
    end
  end

  assign kind   = kind_r;
  assign status = status_r;

  always_comb begin
    sts.op       = op;
    sts.cnt_zero = (cnt == '0);
    sts.cnt_full = (cnt == CW'(QUEUE_DEPTH));
    sts.idx_end  = (idx == cnt);
    sts.idx_zero = (idx == '0);
    sts.hit      = (rdata.id == id_q);
    sts.e_rd     = rdata.is_rd;
    sts.rd_mis   = (rdata.is_rd != rd_q);
    sts.blocked  = blocked;
    sts.nf       = nf;
  end

endmodule
`default_nettype wire

[hdl/rwq_ctrl.sv]
// Sequencer for enqueue, find, shift-delete, dispatch scan and ready query.
`default_nettype none
module rwq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    opcode,
  output logic          busy,
  input  rwq_pkg::sts_t sts,
  output rwq_pkg::ctl_t ctl
);
  import rwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_FRD,
    S_FEV,
    S_SRD,
    S_SWR,
    S_SCAN0,
    S_CRD,
    S_CEV
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load    = 1'b1;
          ctl.idx_clr = 1'b1;
          case (op_t'(opcode))
            OP_ENQ:    state_next = S_ENQ;
            OP_SCAN:   state_next = S_SCAN0;
            default:   state_next = S_FRD;
          endcase
        end
      end
      S_ENQ: begin
        ctl.emit   = 1'b1;
        ctl.o_last = 1'b1;
        if (sts.cnt_full) begin
          ctl.o_status = ST_FULL;
        end else begin
          ctl.wen     = 1'b1;
          ctl.wsel    = W_TAIL;
          ctl.cnt_inc = 1'b1;
        end
        state_next = S_IDLE;
      end
      S_FRD: begin
        if (sts.idx_end) begin
          if (sts.op == OP_QUERY) begin
            ctl.emit     = 1'b1;
            ctl.o_status = ST_NOT_FOUND;
            ctl.o_last   = 1'b1;
            state_next   = S_IDLE;
          end else begin
            ctl.nf_set  = 1'b1;
            ctl.idx_clr = 1'b1;
            state_next  = S_SCAN0;
          end
        end else begin
          state_next = S_FEV;
        end
      end
      S_FEV: begin
        if (sts.hit) begin
          if (sts.op == OP_QUERY) begin
            ctl.emit     = 1'b1;
            ctl.o_status = sts.rd_mis ? ST_MISMATCH : ST_OK;
            ctl.o_ready  = ~sts.blocked;
            ctl.o_last   = 1'b1;
            state_next   = S_IDLE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_SRD;
          end
        end else begin
          ctl.blk_upd = 1'b1;
          ctl.idx_inc = 1'b1;
          state_next  = S_FRD;
        end
      end
      S_SRD: begin
        if (sts.idx_end) begin
          ctl.cnt_dec = 1'b1;
          ctl.idx_clr = 1'b1;
          state_next  = S_SCAN0;
        end else begin
          state_next = S_SWR;
        end
      end
      S_SWR: begin
        ctl.wen     = 1'b1;
        ctl.wsel    = W_PREV;
        ctl.idx_inc = 1'b1;
        state_next  = S_SRD;
      end
      S_SCAN0: begin
        ctl.emit     = 1'b1;
        ctl.o_status = sts.nf ? ST_NOT_FOUND : ST_OK;
        ctl.o_last   = sts.cnt_zero;
        state_next   = sts.cnt_zero ? S_IDLE : S_CRD;
      end
      S_CRD: begin
        if (sts.idx_end) begin
          ctl.emit   = 1'b1;
          ctl.o_kind = KIND_DISPATCH;
          ctl.o_id   = ID_PEND;
          ctl.o_last = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CEV;
        end
      end
      S_CEV: begin
        if (sts.idx_zero) begin
          if (!sts.e_rd) begin
            ctl.emit   = 1'b1;
            ctl.o_kind = KIND_DISPATCH;
            ctl.o_id   = ID_ENTRY;
            ctl.o_last = 1'b1;
            state_next = S_IDLE;
          end else begin
            ctl.pend_load = 1'b1;
            ctl.idx_inc   = 1'b1;
            state_next    = S_CRD;
          end
        end else if (sts.e_rd) begin
          ctl.emit      = 1'b1;
          ctl.o_kind    = KIND_DISPATCH;
          ctl.o_id      = ID_PEND;
          ctl.pend_load = 1'b1;
          ctl.idx_inc   = 1'b1;
          state_next    = S_CRD;
        end else begin
          ctl.emit   = 1'b1;
          ctl.o_kind = KIND_DISPATCH;
          ctl.o_id   = ID_PEND;
          ctl.o_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/reader_writer_request_queue_core.sv]
// Top level of the reader/writer request queue.
// Enqueue answers from the S_ENQ state; a query walks the entries from the
// head and answers at the first match, or with not-found after the last.
// Remove walks, shifts and scans the entries; each visited entry is read
// through the store's registered read before it is evaluated.
// One command at a time; results stream out with no backpressure.
// Reset (rst, synchronous) empties the queue; entry contents stay undefined.
`default_nettype none
module reader_writer_request_queue_core #(
  parameter int QUEUE_DEPTH = rwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic [rwq_pkg::ID_W-1:0] req_id,
  input  logic                     is_read,
  output logic                     strobe,
  output logic                     kind,
  output logic [1:0]               status,
  output logic                     ready_res,
  output logic [rwq_pkg::ID_W-1:0] issued_id,
  output logic                     last
);
  import rwq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rwq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .sts    (sts),
    .ctl    (ctl)
  );

  rwq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .opcode    (opcode),
    .req_id    (req_id),
    .is_read   (is_read),
    .strobe    (strobe),
    .kind      (kind),
    .status    (status),
    .ready_res (ready_res),
    .issued_id (issued_id),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result transfer without a command in progress");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  a_last_ends_cmd: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final result while command still running");

  a_dispatch_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind) |-> (status == ST_OK && !ready_res))
    else $error("dispatch transfer with status or ready set");
`endif

endmodule
`default_nettype wire
